>>> rtl/core/osfl_pkg.sv
// Object slot free list: shared types and codes.
// No dependencies.
package osfl_pkg;

  localparam int unsigned GEN_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ACT_LOAD   = 3'd0,
    ACT_CREATE = 3'd1,
    ACT_DELETE = 3'd2,
    ACT_SAVE   = 3'd3,
    ACT_READ   = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    KIND_FREE     = 3'd0,
    KIND_FREE_MOD = 3'd1,
    KIND_IN_FILE  = 3'd2,
    KIND_IN_STRM  = 3'd3,
    KIND_ADDED    = 3'd4
  } kind_code_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FREE  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [9:0]  object_number;
    logic [2:0]  load_kind;
    logic [30:0] load_offset;
    logic [15:0] load_gen;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  result_index;
    logic [15:0] result_gen;
    logic [2:0]  result_kind;
    logic [30:0] result_offset;
  } rsp_t;

  function automatic logic is_free_kind(input logic [2:0] k);
    is_free_kind = (k == KIND_FREE) || (k == KIND_FREE_MOD);
  endfunction

endpackage

>>> rtl/core/osfl_if.sv
// Valid/ready channel interface carrying a payload of type T.
// Depends on osfl_pkg for the payload types used by the top level.
interface osfl_if #(parameter type T = osfl_pkg::req_t) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/osfl_table.sv
// Slot table memory: one read port with registered data, one write port.
// Does not depend on osfl_pkg.
module osfl_table #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [2:0]    rd_kind,
  output logic [30:0]   rd_link,
  output logic [15:0]   rd_gen,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [2:0]    wr_kind,
  input  logic [30:0]   wr_link,
  input  logic [15:0]   wr_gen
);
  logic [49:0] mem [DEPTH];
  logic [49:0] q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_kind, wr_link, wr_gen};
    end
    q_r <= mem[rd_addr];
  end

  assign rd_kind = q_r[49:47];
  assign rd_link = q_r[46:16];
  assign rd_gen  = q_r[15:0];
endmodule

>>> rtl/core/object_slot_free_list.sv
// Object slot free list. A beat is taken only after the previous one is through. Create's
// chain walk and the neighbor scans of create, delete and save cost one table read per
// visited slot, so cost grows with the distance to the nearest free slots and the chain
// length. The single read port of the slot table sets the pace; a sequencer reuses one
// compare/step unit for every scan. A stalled result beat holds the block busy and keeps
// the input not ready. No clearing pass is needed.
module object_slot_free_list #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic clk,
  input  logic rst_n,
  osfl_if.sink   in_ch,
  osfl_if.source out_ch
);
  localparam int unsigned AW = (TABLE_DEPTH > 1024) ? $clog2(TABLE_DEPTH) : 10;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RADDR = 10'b0000000010,
    S_RWAIT = 10'b0000000100,
    S_EVAL  = 10'b0000001000,
    S_WR1   = 10'b0000010000,
    S_WR2   = 10'b0000100000,
    S_LOWER = 10'b0001000000,
    S_OUT   = 10'b0010000000,
    S_HIGH  = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  // phases of the shared scan unit
  typedef enum logic [5:0] {
    P_SELF  = 6'b000001,
    P_WALK  = 6'b000010,
    P_LOW   = 6'b000100,
    P_HIGH  = 6'b001000,
    P_NONE  = 6'b010000,
    P_READ  = 6'b100000
  } phase_t;

  state_t           state_r, state_nxt;
  phase_t           ph_r;
  osfl_pkg::req_t   req_r;
  osfl_pkg::rsp_t   rsp_r;
  logic             out_v_r;
  logic [CW-1:0]    used_r;
  logic [CW-1:0]    cur_r, steps_r;
  logic [CW-1:0]    tgt_r;      // slot being freed/saved/appended
  logic [CW-1:0]    hi_r;       // result of higher search
  logic [15:0]      gen_r;
  logic [2:0]       kind_r;
  logic [AW-1:0]    rd_addr;
  logic [2:0]       rd_kind;
  logic [30:0]      rd_link;
  logic [15:0]      rd_gen;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [2:0]       wr_kind;
  logic [30:0]      wr_link;
  logic [15:0]      wr_gen;
  logic [CW-1:0]    n_ext;
  logic             rd_free;
  logic [30:0]      rd_link_hold_r;
  logic [15:0]      wr_gen_tgt_r;
  logic [15:0]      wr_gen_calc;
  state_t           acc_state_r;

  osfl_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
    .clk, .rd_addr, .rd_kind, .rd_link, .rd_gen,
    .wr_en, .wr_addr, .wr_kind, .wr_link, .wr_gen
  );

  assign n_ext   = CW'(req_r.object_number);
  assign rd_free = osfl_pkg::is_free_kind(rd_kind);
  assign rd_addr = AW'(cur_r);
  assign in_ch.ready  = (state_r == S_IDLE) && !out_v_r;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = rsp_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  state_nxt = (in_ch.valid && in_ch.ready) ? S_RADDR : S_IDLE;
      default: state_nxt = state_r;
    endcase
  end

  always_comb begin
    case (req_r.action)
      osfl_pkg::ACT_DELETE:
        wr_gen_calc = (gen_r != 16'(osfl_pkg::GEN_MAX)) ? gen_r + 16'd1 : gen_r;
      osfl_pkg::ACT_SAVE: wr_gen_calc = gen_r;
      default:            wr_gen_calc = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    wr_en <= 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
      used_r  <= '0;
      ph_r    <= P_NONE;
    end else begin
      if (out_v_r && out_ch.ready) out_v_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            req_r   <= in_ch.data;
            rsp_r   <= osfl_pkg::rsp_t'({2'b00, in_ch.data.object_number, 50'd0});
            state_r <= S_RADDR;
          end
        end
        S_RADDR: begin
          steps_r <= '0;
          case (req_r.action)
            osfl_pkg::ACT_LOAD: begin
              if (32'(req_r.object_number) >= TABLE_DEPTH) begin
                rsp_r.status <= osfl_pkg::ST_RANGE;
              end else begin
                wr_en   <= 1'b1;
                wr_addr <= AW'(req_r.object_number);
                wr_kind <= req_r.load_kind;
                wr_link <= req_r.load_offset;
                wr_gen  <= req_r.load_gen;
                rsp_r.result_gen <= req_r.load_gen;
                if (used_r < n_ext + CW'(1)) used_r <= n_ext + CW'(1);
              end
              state_r <= S_OUT;
            end
            osfl_pkg::ACT_CREATE: begin
              cur_r <= '0; ph_r <= P_WALK;
              state_r <= S_RWAIT;
            end
            osfl_pkg::ACT_DELETE, osfl_pkg::ACT_SAVE, osfl_pkg::ACT_READ: begin
              if (n_ext >= used_r) begin
                rsp_r.status <= osfl_pkg::ST_RANGE;
                state_r <= S_OUT;
              end else begin
                cur_r <= n_ext; tgt_r <= n_ext;
                ph_r <= (req_r.action == osfl_pkg::ACT_READ) ? P_READ : P_SELF;
                state_r <= S_RWAIT;
              end
            end
            default: begin
              rsp_r.result_index <= '0;
              state_r <= S_OUT;
            end
          endcase
        end
        S_RWAIT: state_r <= S_EVAL;  // memory read latency
        S_EVAL: begin
          state_r <= S_RWAIT;
          case (ph_r)
            P_READ: begin
              rsp_r.result_gen    <= rd_gen;
              rsp_r.result_kind   <= rd_kind;
              rsp_r.result_offset <= rd_link;
              state_r <= S_OUT;
            end
            P_WALK: begin
              if (steps_r >= used_r) begin
                state_r <= S_WR1;
              end else if (rd_free && rd_gen != 16'(osfl_pkg::GEN_MAX)) begin
                rsp_r.result_index <= 10'(cur_r);
                rsp_r.result_gen   <= rd_gen;
                state_r <= S_OUT;
              end else if (rd_link == '0 || rd_link >= 31'(used_r)) begin
                state_r <= S_WR1;
              end else begin
                cur_r   <= CW'(rd_link);
                steps_r <= steps_r + CW'(1);
              end
            end
            P_SELF: begin
              gen_r  <= rd_gen;
              kind_r <= rd_kind;
              if (req_r.action == osfl_pkg::ACT_DELETE) begin
                if (rd_free) begin
                  rsp_r.status <= osfl_pkg::ST_FREE;
                  state_r <= S_OUT;
                end else begin
                  hi_r <= '0; cur_r <= tgt_r + CW'(1); ph_r <= P_HIGH;
                  if (tgt_r + CW'(1) >= used_r) state_r <= S_WR1;
                end
              end else begin
                rsp_r.result_gen <= rd_gen;
                if (rd_free) begin
                  hi_r <= '0; cur_r <= tgt_r + CW'(1); ph_r <= P_HIGH;
                  if (tgt_r + CW'(1) >= used_r) state_r <= S_WR1;
                end else begin
                  state_r <= S_WR1;
                end
              end
            end
            P_HIGH: begin
              if (rd_free) begin
                hi_r <= cur_r; state_r <= S_WR1;
              end else if (cur_r + CW'(1) >= used_r) begin
                state_r <= S_WR1;
              end else begin
                cur_r <= cur_r + CW'(1);
              end
            end
            P_LOW: begin
              if (rd_free || cur_r == '0) begin
                state_r <= S_WR2;
              end else begin
                cur_r <= cur_r - CW'(1);
              end
            end
            default: state_r <= S_OUT;
          endcase
        end
        S_WR1: begin
          // write target, then search lower; full create and used-slot save end early
          state_r <= S_LOWER;
          case (req_r.action)
            osfl_pkg::ACT_CREATE: begin
              if (32'(used_r) >= TABLE_DEPTH) begin
                rsp_r.status <= osfl_pkg::ST_FULL;
                rsp_r.result_index <= '0;
                state_r <= S_OUT;
              end else begin
                tgt_r  <= used_r;
                used_r <= used_r + CW'(1);
                wr_en <= 1'b1; wr_addr <= AW'(used_r);
                wr_kind <= osfl_pkg::KIND_FREE_MOD; wr_link <= '0; wr_gen <= '0;
                rsp_r.result_index <= 10'(used_r);
                rsp_r.result_gen <= '0;
              end
            end
            osfl_pkg::ACT_DELETE: begin
              wr_en <= 1'b1; wr_addr <= AW'(tgt_r);
              wr_kind <= osfl_pkg::KIND_FREE_MOD; wr_link <= 31'(hi_r);
              wr_gen <= (gen_r != 16'(osfl_pkg::GEN_MAX)) ? gen_r + 16'd1 : gen_r;
              rsp_r.result_gen <=
                (gen_r != 16'(osfl_pkg::GEN_MAX)) ? gen_r + 16'd1 : gen_r;
            end
            default: begin // save
              wr_en <= 1'b1; wr_addr <= AW'(tgt_r);
              wr_kind <= osfl_pkg::KIND_ADDED; wr_link <= rd_link_hold_r; wr_gen <= gen_r;
              if (!osfl_pkg::is_free_kind(kind_r)) state_r <= S_OUT;
            end
          endcase
        end
        S_LOWER: begin
          ph_r <= P_LOW;
          if (tgt_r == '0) begin
            cur_r <= '0; state_r <= S_WR2;
          end else begin
            cur_r <= tgt_r - CW'(1); state_r <= S_RWAIT;
          end
        end
        S_WR2: begin
          // saving slot 0 relinks slot 0 itself, which stays added
          wr_en <= 1'b1; wr_addr <= AW'(cur_r);
          wr_kind <= (req_r.action == osfl_pkg::ACT_SAVE && cur_r == tgt_r) ?
                     osfl_pkg::KIND_ADDED : osfl_pkg::KIND_FREE_MOD;
          wr_link <= (req_r.action == osfl_pkg::ACT_SAVE) ? 31'(hi_r) : 31'(tgt_r);
          wr_gen <= (cur_r == tgt_r) ? wr_gen_tgt_r : rd_gen;
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_v_r <= 1'b1;
          state_r <= S_FIN;
        end
        default: begin // S_FIN
          if (!out_v_r || out_ch.ready) state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Link of the saved slot is kept; capture it on the self read.
  always_ff @(posedge clk) begin
    if (state_r == S_EVAL && ph_r == P_SELF) rd_link_hold_r <= rd_link;
    if (state_r == S_WR1) wr_gen_tgt_r <= wr_gen_calc;
  end

  // state_nxt only models the idle exit; used by the assertion below
  always_ff @(posedge clk) acc_state_r <= state_nxt;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_ch.valid && in_ch.ready) |=> state_r == acc_state_r)
    else $error("accept did not start a sequence");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !in_ch.ready) else $error("accepted while result pending");
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_r) <= TABLE_DEPTH) else $error("slot count above depth");
endmodule

>>> tb/tb_top.sv
// Testbench for object_slot_free_list: directed and random slot-table actions
// checked against an in-bench predictor. Depends on osfl_pkg and osfl_if.
module tb_top;

  localparam int unsigned DEPTH = 1024;

  // Slot table predictor plus the queue of expected response beats.
  class slot_table_sb;
    logic [2:0]  kind_q [DEPTH];
    logic [30:0] link_q [DEPTH];
    logic [15:0] gen_q  [DEPTH];
    int unsigned used;
    osfl_pkg::rsp_t pending_q[$];
    int          errors;

    function new();
      used = 0;
      errors = 0;
      foreach (kind_q[i]) begin
        kind_q[i] = '0;
        link_q[i] = '0;
        gen_q[i] = '0;
      end
    endfunction

    function bit free_at(int unsigned i);
      return kind_q[i] == osfl_pkg::KIND_FREE || kind_q[i] == osfl_pkg::KIND_FREE_MOD;
    endfunction

    function int unsigned lower_free(int unsigned n);
      int unsigned p;
      p = n;
      while (p > 0) begin
        p--;
        if (free_at(p)) return p;
      end
      return 0;
    endfunction

    function int unsigned higher_free(int unsigned n);
      for (int unsigned p = n + 1; p < used; p++)
        if (free_at(p)) return p;
      return 0;
    endfunction

    function osfl_pkg::rsp_t predict(osfl_pkg::req_t r);
      osfl_pkg::rsp_t e;
      int unsigned n, cur, nxt, p, q, id;
      bit          found;
      n = 32'(r.object_number);
      e = '0;
      e.status = osfl_pkg::ST_OK;
      e.result_index = r.object_number;
      case (r.action)
        osfl_pkg::ACT_LOAD: begin
          kind_q[n] = r.load_kind;
          link_q[n] = r.load_offset;
          gen_q[n] = r.load_gen;
          if (used < n + 1) used = n + 1;
          e.result_gen = r.load_gen;
        end
        osfl_pkg::ACT_CREATE: begin
          cur = 0;
          found = 0;
          for (int unsigned s = 0; s < used; s++) begin
            if (free_at(cur) && gen_q[cur] != 16'hFFFF) begin
              found = 1;
              break;
            end
            nxt = 32'(link_q[cur]);
            if (nxt == 0 || nxt >= used) break;
            cur = nxt;
          end
          if (found) begin
            e.result_index = 10'(cur);
            e.result_gen = gen_q[cur];
          end else if (used >= DEPTH) begin
            e.status = osfl_pkg::ST_FULL;
            e.result_index = '0;
          end else begin
            id = used;
            used++;
            kind_q[id] = osfl_pkg::KIND_FREE_MOD;
            link_q[id] = '0;
            gen_q[id] = '0;
            p = lower_free(id);
            kind_q[p] = osfl_pkg::KIND_FREE_MOD;
            link_q[p] = 31'(id);
            e.result_index = 10'(id);
          end
        end
        osfl_pkg::ACT_DELETE: begin
          if (n >= used) e.status = osfl_pkg::ST_RANGE;
          else if (free_at(n)) e.status = osfl_pkg::ST_FREE;
          else begin
            kind_q[n] = osfl_pkg::KIND_FREE_MOD;
            link_q[n] = 31'(higher_free(n));
            if (gen_q[n] != 16'hFFFF) gen_q[n]++;
            p = lower_free(n);
            kind_q[p] = osfl_pkg::KIND_FREE_MOD;
            link_q[p] = 31'(n);
            e.result_gen = gen_q[n];
          end
        end
        osfl_pkg::ACT_SAVE: begin
          if (n >= used) e.status = osfl_pkg::ST_RANGE;
          else begin
            if (free_at(n)) begin
              p = lower_free(n);
              q = higher_free(n);
              kind_q[p] = osfl_pkg::KIND_FREE_MOD;
              link_q[p] = 31'(q);
            end
            kind_q[n] = osfl_pkg::KIND_ADDED;
            e.result_gen = gen_q[n];
          end
        end
        osfl_pkg::ACT_READ: begin
          if (n >= used) e.status = osfl_pkg::ST_RANGE;
          else begin
            e.result_gen = gen_q[n];
            e.result_kind = kind_q[n];
            e.result_offset = link_q[n];
          end
        end
        default: e.result_index = '0;
      endcase
      return e;
    endfunction

    function void note(osfl_pkg::req_t r);
      pending_q.push_back(predict(r));
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check(osfl_pkg::rsp_t got);
      osfl_pkg::rsp_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("response beat with nothing pending: %h", got));
      end else begin
        e = pending_q.pop_front();
        if (got.status !== e.status)
          report($sformatf("status %0d, want %0d", got.status, e.status));
        if (got.result_index !== e.result_index)
          report($sformatf("index %0d, want %0d", got.result_index, e.result_index));
        if (got.result_gen !== e.result_gen)
          report($sformatf("gen %0d, want %0d", got.result_gen, e.result_gen));
        if (got.result_kind !== e.result_kind)
          report($sformatf("kind %0d, want %0d", got.result_kind, e.result_kind));
        if (got.result_offset !== e.result_offset)
          report($sformatf("offset %h, want %h", got.result_offset, e.result_offset));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  osfl_if #(.T(osfl_pkg::req_t)) in_ch (clk);
  osfl_if #(.T(osfl_pkg::rsp_t)) out_ch (clk);

  object_slot_free_list #(.TABLE_DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  slot_table_sb sb = new();
  int burst_left = 0;
  bit hold_req = 0;
  int hold_left = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #200000000;
    $display("status: fail");
    $finish;
  end

  // Response side: ready mixes always-high, random, mostly-low and held-low modes.
  initial begin
    int mode, mode_left;
    mode = 0;
    mode_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 400;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (mode == 0) out_ch.ready <= 1'b1;
      else if (mode == 1) out_ch.ready <= 1'($urandom_range(0, 1));
      else out_ch.ready <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk)
    if (rst_n && out_ch.valid && out_ch.ready) sb.check(out_ch.data);

  function automatic osfl_pkg::req_t mk(logic [2:0] a, int unsigned n,
                                        logic [2:0] k = osfl_pkg::KIND_FREE,
                                        logic [30:0] o = '0, logic [15:0] g = '0);
    osfl_pkg::req_t r;
    r.action = a;
    r.object_number = 10'(n);
    r.load_kind = k;
    r.load_offset = o;
    r.load_gen = g;
    return r;
  endfunction

  task automatic send_beat(input osfl_pkg::req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= r;
    do @(posedge clk); while (!in_ch.ready);
    sb.note(r);
    burst_left--;
  endtask

  // Random beat; loads never leave a hole, so no scan touches an unwritten slot.
  function automatic osfl_pkg::req_t rand_beat();
    osfl_pkg::req_t r;
    int unsigned sel, top, n;
    sel = $urandom_range(0, 99);
    r.load_kind = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                 : $urandom_range(0, 4));
    r.load_offset = 31'(($urandom_range(0, 1) != 0) ? $urandom_range(0, sb.used + 2)
                                                    : $urandom());
    case ($urandom_range(0, 3))
      0: r.load_gen = 16'hFFFF;
      1: r.load_gen = 16'hFFFE;
      default: r.load_gen = 16'($urandom());
    endcase
    top = (sb.used + 3 > DEPTH - 1) ? DEPTH - 1 : sb.used + 3;
    n = $urandom_range(0, top);
    if (sel < 20) begin
      r.action = osfl_pkg::ACT_LOAD;
      top = (sb.used >= 48 || sb.used == DEPTH) ? sb.used - 1 : sb.used;
      if (sb.used == 0) top = 0;
      n = $urandom_range(0, top);
    end else if (sel < 35)
      r.action = (sb.used < 200) ? osfl_pkg::ACT_CREATE : osfl_pkg::ACT_READ;
    else if (sel < 55) r.action = osfl_pkg::ACT_DELETE;
    else if (sel < 70) r.action = osfl_pkg::ACT_SAVE;
    else if (sel < 95) r.action = osfl_pkg::ACT_READ;
    else r.action = 3'($urandom_range(5, 7));
    if (r.action != osfl_pkg::ACT_LOAD && $urandom_range(0, 19) == 0)
      n = $urandom_range(0, DEPTH - 1);
    r.object_number = 10'(n);
    return r;
  endfunction

  initial begin
    int waited;
    osfl_pkg::req_t r;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    send_beat(mk(osfl_pkg::ACT_LOAD, 0, osfl_pkg::KIND_FREE, 31'd0, 16'd0));
    send_beat(mk(osfl_pkg::ACT_CREATE, 0));
    send_beat(mk(osfl_pkg::ACT_READ, 0));
    send_beat(mk(osfl_pkg::ACT_LOAD, 0, osfl_pkg::KIND_IN_FILE, 31'h7FFFFFFF, 16'hFFFF));
    send_beat(mk(osfl_pkg::ACT_READ, 0));
    send_beat(mk(osfl_pkg::ACT_CREATE, 0));
    send_beat(mk(osfl_pkg::ACT_READ, 0));
    send_beat(mk(osfl_pkg::ACT_LOAD, 1, osfl_pkg::KIND_IN_STRM, 31'd5, 16'hFFFE));
    send_beat(mk(osfl_pkg::ACT_LOAD, 2, osfl_pkg::KIND_ADDED, 31'd0, 16'hFFFF));
    send_beat(mk(osfl_pkg::ACT_DELETE, 1));
    send_beat(mk(osfl_pkg::ACT_DELETE, 2));
    send_beat(mk(osfl_pkg::ACT_DELETE, 1));
    send_beat(mk(osfl_pkg::ACT_CREATE, 0));
    send_beat(mk(osfl_pkg::ACT_SAVE, 1));
    send_beat(mk(osfl_pkg::ACT_SAVE, 2));
    send_beat(mk(osfl_pkg::ACT_READ, 9));
    send_beat(mk(osfl_pkg::ACT_DELETE, 900));
    send_beat(mk(osfl_pkg::ACT_SAVE, 900));
    send_beat(mk(3'd5, 1));
    send_beat(mk(3'd6, 2));
    send_beat(mk(3'd7, 1023, 3'd7, 31'h7FFFFFFF, 16'hFFFF));
    send_beat(mk(osfl_pkg::ACT_LOAD, 3, 3'd7, 31'h2AAAAAAA, 16'h5555));
    send_beat(mk(osfl_pkg::ACT_DELETE, 3));
    send_beat(mk(osfl_pkg::ACT_READ, 3));
    send_beat(mk(osfl_pkg::ACT_CREATE, 0));

    // random, with one long response stall in the middle
    for (int i = 0; i < 700; i++) begin
      if (i == 300) hold_req = 1;
      send_beat(rand_beat());
    end

    // grow the table to full depth, then exercise a full table
    send_beat(mk(osfl_pkg::ACT_LOAD, 0, osfl_pkg::KIND_IN_FILE, 31'd0, 16'($urandom())));
    while (sb.used < DEPTH) begin
      r = mk(osfl_pkg::ACT_LOAD, sb.used,
             ($urandom_range(0, 7) == 0) ? osfl_pkg::KIND_FREE : osfl_pkg::KIND_IN_FILE,
             31'($urandom()), ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom()));
      if (r.load_kind == osfl_pkg::KIND_FREE) r.load_gen = 16'hFFFF;
      send_beat(r);
    end
    send_beat(mk(osfl_pkg::ACT_LOAD, 0, osfl_pkg::KIND_IN_FILE, 31'd0, 16'h1234));
    send_beat(mk(osfl_pkg::ACT_CREATE, 0));
    send_beat(mk(osfl_pkg::ACT_READ, 1023));
    send_beat(mk(osfl_pkg::ACT_DELETE, 1023));
    send_beat(mk(osfl_pkg::ACT_CREATE, 0));
    for (int i = 0; i < 40; i++) send_beat(rand_beat());

    in_ch.valid <= 1'b0;
    waited = 0;
    while (sb.pending_q.size() != 0 && waited < 500000) begin
      @(posedge clk);
      waited++;
    end
    if (waited >= 500000) begin
      $display("status: fail");
      $finish;
    end else begin
      repeat (8000) @(posedge clk);
      if (sb.errors == 0 && sb.pending_q.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
    end
  end
endmodule
